### hdl/etg_pkg.sv
// Package with shared types and constants for the enveloped tone generator.
package etg_pkg;

    localparam int AMP_W    = 15;
    localparam int SPM_W    = 8;
    localparam int EDGE_W   = 12;
    localparam int STEP_W   = 32;
    localparam int MS_W     = 12;
    localparam int IDX_W    = 20;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    // Sine polynomial datapath widths.
    localparam int Z_W      = 16;
    localparam int T_W      = 12;
    localparam int U_W      = 15;
    localparam int S_W      = 15;
    localparam int SA_W     = 30;
    localparam int Y_W      = 27;
    localparam int Q_W      = 15;
    localparam int MUL_A_W  = 30;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC     = 15;

    localparam logic [T_W-1:0]     SINE_C3 = 12'd2320;
    localparam logic [U_W-1:0]     SINE_C2 = 15'd21024;
    localparam logic [Z_W-1:0]     SINE_C1 = 16'd51472;

    localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd7000;
    localparam logic [SPM_W-1:0]  SPM_RESET  = 8'd16;
    localparam logic [EDGE_W-1:0] EDGE_RESET = 12'd128;

    // The quotient has Q_W bits, one restoring step per bit.
    localparam int CNT_W     = 4;
    localparam int DIV_STEPS = Q_W;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE      = 2'd0,
        CFG_SAMPLES_PER_MS = 2'd1,
        CFG_EDGE_SAMPLES   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MS_ZZ,
        MS_T,
        MS_U,
        MS_S,
        MS_AMP,
        MS_ENV
    } t_mul_sel;

    typedef struct packed {
        logic     load_start;
        logic     load_tick;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_init;
        logic     div_step;
        logic     out_load;
        logic     out_silent;
    } t_dp_cmd;

    typedef struct packed {
        logic playing;
        logic out_busy;
    } t_dp_sts;

endpackage

### hdl/enveloped_tone_generator_top.sv
// Top level of the enveloped sine tone generator.
//
// The input channel (i_in_valid / o_in_ready) carries one beat per item. A beat with
// operation START loads the phase step and the duration in milliseconds; the tone
// length becomes tone_ms times samples_per_ms samples and the phase restarts at zero.
// A START beat returns nothing. A beat with operation TICK returns one beat on the
// output channel (o_out_valid / i_out_ready): the sine sample scaled by amplitude and
// the linear attack/release envelope, with tone_active and last_of_tone flags. A TICK
// while no tone plays returns a silent beat.
// A START beat is loaded as it is accepted, and the block stays ready for the next beat.
// A TICK during a tone puts its beat on the output after six multiplier steps for the
// sine polynomial and scaling, one divider load, fifteen restoring divider steps and
// one emit step; an idle TICK goes straight to the emit step. One tick is in flight at
// a time: the next input beat is taken only once the emit step is done.
// The output register holds a finished beat while the receiver stalls; the block
// already takes the next input beat, and a new result waits in its emit step until
// the register is free. Configuration writes take effect at once.
// Reset (synchronous, active low) stops any tone, empties the output register and
// restores amplitude 7000, samples_per_ms 16 and edge_samples 128.
// SINE_TABLE_DEPTH must be a power of two.
module enveloped_tone_generator_top
    import etg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic [STEP_W-1:0]          i_phase_step,
    input  logic [MS_W-1:0]            i_tone_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_value,
    output logic                       o_tone_active,
    output logic                       o_last_of_tone,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wr_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: accepts beats and walks the datapath through each tick.
    etg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: tone state, multiplier, divider and output register.
    etg_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_phase_step   (i_phase_step),
        .i_tone_ms      (i_tone_ms),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_tone_active  (o_tone_active),
        .o_last_of_tone (o_last_of_tone)
    );

endmodule

### hdl/etg_ctrl.sv
// Sequencer that steps the tone datapath through one sample computation.
module etg_ctrl
    import etg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZZ,
        S_T,
        S_U,
        S_S,
        S_AMP,
        S_ENV,
        S_DIV_INIT,
        S_DIV,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_silent;
    logic             w_accept;
    logic             w_tick;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_accept   = i_in_valid && o_in_ready;
        w_tick     = (t_op'(i_operation) == OP_TICK);

        o_cmd            = '0;
        o_cmd.mul_sel    = MS_ZZ;
        o_cmd.load_start = w_accept && !w_tick;
        o_cmd.load_tick  = w_accept && w_tick;
        case (r_state)
            S_ZZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_ZZ;
            end
            S_T: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T;
            end
            S_U: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_U;
            end
            S_S: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_S;
            end
            S_AMP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_AMP;
            end
            S_ENV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_ENV;
            end
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_EMIT: begin
                o_cmd.out_load   = !i_sts.out_busy;
                o_cmd.out_silent = r_silent;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_silent <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_tick) begin
                        r_silent <= !i_sts.playing;
                        r_state  <= i_sts.playing ? S_ZZ : S_EMIT;
                    end
                end
                S_ZZ:  r_state <= S_T;
                S_T:   r_state <= S_U;
                S_U:   r_state <= S_S;
                S_S:   r_state <= S_AMP;
                S_AMP: r_state <= S_ENV;
                S_ENV: r_state <= S_DIV_INIT;
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded while previous one still waits");

    // A tick during a tone starts the sine computation; an idle tick goes to emit.
    a_tick_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_tick && i_sts.playing) |=> (r_state == S_ZZ) && !r_silent)
        else $error("tick during tone did not start computation");

endmodule

### hdl/etg_dp.sv
// Datapath: configuration, tone state, shared multiplier, divider and output register.
module etg_dp
    import etg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wr_data,
    input  logic [STEP_W-1:0]          i_phase_step,
    input  logic [MS_W-1:0]            i_tone_ms,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_value,
    output logic                       o_tone_active,
    output logic                       o_last_of_tone
);

    localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);

    // Configuration registers.
    logic [AMP_W-1:0]  r_amp;
    logic [SPM_W-1:0]  r_spm;
    logic [EDGE_W-1:0] r_edge;

    // Tone state.
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_len;
    logic                  r_playing;

    // Per-sample operands and intermediate results.
    logic [Z_W-1:0]    r_z;
    logic              r_neg;
    logic [EDGE_W-1:0] r_num;
    logic [EDGE_W-1:0] r_den;
    logic              r_last;
    logic [Z_W-1:0]    r_z2;
    logic [T_W-1:0]    r_t;
    logic [U_W-1:0]    r_u;
    logic [S_W-1:0]    r_s;
    logic [SA_W-1:0]   r_sa;
    logic [Y_W-1:0]    r_y;
    logic [EDGE_W-1:0] r_rem;
    logic [Q_W-1:0]    r_q;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value;
    logic                       r_out_active;
    logic                       r_out_last;

    logic [TBL_BITS-1:0]  w_k;
    logic [STEP_W-1:0]    w_p;
    logic [STEP_W-3:0]    w_r;
    logic [STEP_W-2:0]    w_rr;
    logic [IDX_W-1:0]     w_len;
    logic                 w_attack;
    logic                 w_release;
    logic                 w_last;
    logic [IDX_W-1:0]     w_left;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]    w_prod;
    logic [Z_W-1:0]       w_s_raw;
    logic [EDGE_W:0]      w_rem_sh;
    logic                 w_ge;
    logic [EDGE_W:0]      w_rem_sub;

    always_comb begin
        // Table index on the top phase bits, then the phase as a fraction of 2^32.
        w_k  = r_phase[PHASE_BITS-1 -: TBL_BITS];
        w_p  = STEP_W'(w_k) << (STEP_W - TBL_BITS);
        w_r  = w_p[STEP_W-3:0];
        w_rr = w_p[STEP_W-2] ? ({1'b1, {(STEP_W-2){1'b0}}} - {1'b0, w_r}) : {1'b0, w_r};

        w_len     = {{(IDX_W-MS_W){1'b0}}, i_tone_ms} * {{(IDX_W-SPM_W){1'b0}}, r_spm};
        w_attack  = r_idx < {{(IDX_W-EDGE_W){1'b0}}, r_edge};
        w_release = ({1'b0, r_idx} + {{(IDX_W+1-EDGE_W){1'b0}}, r_edge}) > {1'b0, r_len};
        w_last    = ({1'b0, r_idx} + {{IDX_W{1'b0}}, 1'b1}) >= {1'b0, r_len};
        w_left    = r_len - r_idx;

        case (i_cmd.mul_sel)
            MS_ZZ: begin
                w_mul_a = MUL_A_W'(r_z);
                w_mul_b = r_z;
            end
            MS_T: begin
                w_mul_a = MUL_A_W'(SINE_C3);
                w_mul_b = r_z2;
            end
            MS_U: begin
                w_mul_a = MUL_A_W'(r_z2);
                w_mul_b = MUL_B_W'(SINE_C2 - U_W'(r_t));
            end
            MS_S: begin
                w_mul_a = MUL_A_W'(r_z);
                w_mul_b = SINE_C1 - MUL_B_W'(r_u);
            end
            MS_AMP: begin
                w_mul_a = MUL_A_W'(r_s);
                w_mul_b = MUL_B_W'(r_amp);
            end
            MS_ENV: begin
                w_mul_a = r_sa;
                w_mul_b = MUL_B_W'(r_num);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        w_s_raw = w_prod[FRAC +: Z_W];

        // Restoring division step on the scaled magnitude.
        w_rem_sh  = {r_rem, r_q[Q_W-1]};
        w_ge      = w_rem_sh >= {1'b0, r_den};
        w_rem_sub = w_rem_sh - {1'b0, r_den};

        o_sts.playing  = r_playing;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp     <= AMP_RESET;
            r_spm     <= SPM_RESET;
            r_edge    <= EDGE_RESET;
            r_phase   <= '0;
            r_step    <= '0;
            r_idx     <= '0;
            r_len     <= '0;
            r_playing <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_AMPLITUDE:      r_amp  <= i_cfg_wr_data[AMP_W-1:0];
                    CFG_SAMPLES_PER_MS: r_spm  <= i_cfg_wr_data[SPM_W-1:0];
                    CFG_EDGE_SAMPLES:   r_edge <= i_cfg_wr_data[EDGE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_start) begin
                r_step    <= i_phase_step[PHASE_BITS-1:0];
                r_len     <= w_len;
                r_phase   <= '0;
                r_idx     <= '0;
                r_playing <= (w_len != '0);
            end else if (i_cmd.load_tick && r_playing) begin
                r_phase <= r_phase + r_step;
                r_idx   <= r_idx + 1'b1;
                if (w_last) begin
                    r_playing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick && r_playing) begin
            r_z    <= w_rr[STEP_W-2 -: Z_W];
            r_neg  <= w_p[STEP_W-1];
            r_last <= w_last;
            if (w_attack) begin
                r_num <= r_idx[EDGE_W-1:0];
                r_den <= r_edge;
            end else if (w_release) begin
                r_num <= w_left[EDGE_W-1:0];
                r_den <= r_edge;
            end else begin
                r_num <= EDGE_W'(1);
                r_den <= EDGE_W'(1);
            end
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MS_ZZ:  r_z2 <= w_prod[FRAC +: Z_W];
                MS_T:   r_t  <= w_prod[FRAC +: T_W];
                MS_U:   r_u  <= w_prod[FRAC +: U_W];
                MS_S:   r_s  <= w_s_raw[Z_W-1] ? {S_W{1'b1}} : w_s_raw[S_W-1:0];
                MS_AMP: r_sa <= w_prod[SA_W-1:0];
                MS_ENV: r_y  <= w_prod[FRAC +: Y_W];
                default: ;
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem <= r_y[Y_W-1 -: EDGE_W];
            r_q   <= r_y[Q_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[EDGE_W-1:0] : w_rem_sh[EDGE_W-1:0];
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_silent) begin
                r_out_value  <= '0;
                r_out_active <= 1'b0;
                r_out_last   <= 1'b0;
            end else begin
                r_out_value  <= r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
                r_out_active <= 1'b1;
                r_out_last   <= r_last;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_tone_active  = r_out_active;
    assign o_last_of_tone = r_out_last;

    // The envelope fraction never exceeds one.
    a_env_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_tick && r_playing) |=> (r_num < r_den) || (r_num == r_den && r_den == 1))
        else $error("envelope numerator out of range");

    // The partial remainder stays below the divisor, so the quotient fits.
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

endmodule
